### hw/rtl/qte_pkg.sv
// Shared constants, widths and helper functions for the quaternion to Euler core.
// Used by qte_cordic and quaternion_to_euler_degrees_core; no dependencies.
`timescale 1ns / 1ps

package qte_pkg;

    localparam int QW            = 16;          // quaternion component width, Q1.15
    localparam int PW            = 2 * QW;      // product width
    localparam int SW            = PW + 2;      // doubled sums and differences
    localparam int DW            = PW + 1;      // squared norm, divider remainder
    localparam int CORDIC_STAGES = 16;
    localparam int CW            = 38;          // CORDIC x/y datapath width
    localparam int AW            = 26;          // angle accumulator, 1/65536 degree
    localparam int ROUND_SH      = 9;           // 1/65536 -> 1/128 degree
    localparam int RW            = AW - ROUND_SH;
    localparam int DIV_STEPS     = 30;          // quotient bits of the asin argument
    localparam int QB            = DIV_STEPS;   // asin argument fraction bits
    localparam int SQRT_STEPS    = QB + 1;      // root bits of 2^60 - s^2
    localparam int RMW           = 2 * QB + 1;  // radicand width
    localparam int SQW           = QB + 2;      // signed asin argument width

    localparam int ANG180        = 180 * 65536;
    localparam int ROLL_LIM      = 23040;
    localparam int PITCH_LIM     = 11520;

    localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
    localparam int PDLY          = 1 + DIV_STEPS + 3 + SQRT_STEPS;
    localparam int LATENCY       = 3 + PDLY + CORDIC_LAT;

    // Elementary angles atan(2^-k) in 1/65536 degree, rounded.
    function automatic logic signed [AW-1:0] atan_ang(input int k);
        logic signed [AW-1:0] a;
        begin
            unique case (k)
                0:  a = AW'(2949120);
                1:  a = AW'(1740967);
                2:  a = AW'(919879);
                3:  a = AW'(466945);
                4:  a = AW'(234379);
                5:  a = AW'(117304);
                6:  a = AW'(58666);
                7:  a = AW'(29335);
                8:  a = AW'(14668);
                9:  a = AW'(7334);
                10: a = AW'(3667);
                11: a = AW'(1833);
                12: a = AW'(917);
                13: a = AW'(458);
                14: a = AW'(229);
                15: a = AW'(115);
                16: a = AW'(57);
                17: a = AW'(29);
                18: a = AW'(14);
                19: a = AW'(7);
                20: a = AW'(4);
                21: a = AW'(2);
                22: a = AW'(1);
                default: a = '0;
            endcase
            return a;
        end
    endfunction

    // Clamp a rounded angle to +-lim.
    function automatic logic signed [RW-1:0] clamp_ang(input logic signed [RW-1:0] v,
                                                       input int lim);
        logic signed [RW-1:0] l;
        begin
            l = RW'(lim);
            if (v > l) return l;
            if (v < -l) return -l;
            return v;
        end
    endfunction

endpackage

### hw/rtl/qte_cordic.sv
// Pipelined vectoring CORDIC: angle of (x, y), rounded to 1/128 degree.
// Depends on qte_pkg for widths, stage count and the arctangent table.
`timescale 1ns / 1ps

module qte_cordic import qte_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic                 o_vld,
    output logic signed [RW-1:0] o_ang
);

    logic signed [CW-1:0] r_x [0:CORDIC_STAGES];
    logic signed [CW-1:0] r_y [0:CORDIC_STAGES];
    logic signed [AW-1:0] r_a [0:CORDIC_STAGES];
    logic [CORDIC_STAGES:0] r_z;
    logic [CORDIC_STAGES:0] r_v;

    logic signed [CW-1:0] n_x [1:CORDIC_STAGES];
    logic signed [CW-1:0] n_y [1:CORDIC_STAGES];
    logic signed [AW-1:0] n_a [1:CORDIC_STAGES];
    logic signed [AW-1:0] w_rnd;

    // one micro-rotation per stage, direction from the sign of y
    always_comb begin
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            if (!r_y[k][CW-1]) begin
                n_x[k+1] = r_x[k] + (r_y[k] >>> k);
                n_y[k+1] = r_y[k] - (r_x[k] >>> k);
                n_a[k+1] = r_a[k] + atan_ang(k);
            end else begin
                n_x[k+1] = r_x[k] - (r_y[k] >>> k);
                n_y[k+1] = r_y[k] + (r_x[k] >>> k);
                n_a[k+1] = r_a[k] - atan_ang(k);
            end
        end
    end

    assign w_rnd = r_a[CORDIC_STAGES] + AW'(1 << (ROUND_SH - 1));

    always_ff @(posedge i_clk) begin
        // pre-rotation: fold the left half-plane by 180 degrees
        r_z[0] <= (i_x == '0) && (i_y == '0);
        if (i_x[CW-1]) begin
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
            r_a[0] <= i_y[CW-1] ? -AW'(ANG180) : AW'(ANG180);
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_a[0] <= '0;
        end
        for (int k = 1; k <= CORDIC_STAGES; k++) begin
            r_x[k] <= n_x[k];
            r_y[k] <= n_y[k];
            r_a[k] <= n_a[k];
            r_z[k] <= r_z[k-1];
        end
        o_ang <= r_z[CORDIC_STAGES] ? '0 : w_rnd[AW-1:ROUND_SH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            o_vld <= 1'b0;
        end else begin
            r_v   <= {r_v[CORDIC_STAGES-1:0], i_vld};
            o_vld <= r_v[CORDIC_STAGES];
        end
    end

endmodule

### hw/rtl/quaternion_to_euler_degrees_core.sv
// Top level: quaternion (Q1.15) to roll, pitch and negated yaw in 1/128 degree.
// Depends on qte_pkg and qte_cordic (three instances).
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  --------------------------------------
//  command   in         start & !busy          i_quat_w, i_quat_x, i_quat_y, i_quat_z
//  result    out        o_valid (one cycle)    o_roll_deg, o_pitch_deg, o_yaw_deg,
//                                              o_invalid
//
//  A word may be started in every cycle; busy is held low and the pipeline
//  never stops. A result's delay is set by the asin path: 30 restoring divider
//  steps, 31 root steps and the 18-deep CORDIC, one bit or one rotation per
//  stage.
//  Reset (i_rst_n low, synchronous) drops every word in flight.
//  The receiver cannot stall, so results leave in order, one per strobe.

module quaternion_to_euler_degrees_core import qte_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [QW-1:0] i_quat_w,
    input  logic signed [QW-1:0] i_quat_x,
    input  logic signed [QW-1:0] i_quat_y,
    input  logic signed [QW-1:0] i_quat_z,
    output logic                 o_valid,
    output logic signed [15:0]   o_roll_deg,
    output logic signed [14:0]   o_pitch_deg,
    output logic signed [15:0]   o_yaw_deg,
    output logic                 o_invalid
);

    // ------------------------------------------------------------------
    // Stage 1: the ten products, all exact in 32 bits.
    // ------------------------------------------------------------------
    logic                 r_s1_vld;
    logic signed [PW-1:0] r_p_ww, r_p_xx, r_p_yy, r_p_zz;
    logic signed [PW-1:0] r_p_yz, r_p_xw, r_p_xy, r_p_zw, r_p_yw, r_p_xz;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        r_p_ww <= i_quat_w * i_quat_w;
        r_p_xx <= i_quat_x * i_quat_x;
        r_p_yy <= i_quat_y * i_quat_y;
        r_p_zz <= i_quat_z * i_quat_z;
        r_p_yz <= i_quat_y * i_quat_z;
        r_p_xw <= i_quat_x * i_quat_w;
        r_p_xy <= i_quat_x * i_quat_y;
        r_p_zw <= i_quat_z * i_quat_w;
        r_p_yw <= i_quat_y * i_quat_w;
        r_p_xz <= i_quat_x * i_quat_z;
    end

    // ------------------------------------------------------------------
    // Stage 2: atan2 operands, squared norm and the asin numerator.
    // ------------------------------------------------------------------
    logic                 r_s2_vld;
    logic                 r_s2_inv;
    logic signed [SW-1:0] r_s2_den, r_s2_num;
    logic signed [SW-1:0] r_roll_x, r_roll_y, r_yaw_x, r_yaw_y;
    logic signed [SW-1:0] w_den;

    assign w_den = SW'(r_p_ww) + SW'(r_p_xx) + SW'(r_p_yy) + SW'(r_p_zz);

    always_ff @(posedge i_clk) begin
        r_s2_den <= w_den;
        r_s2_inv <= (w_den == '0);
        r_roll_y <= (SW'(r_p_yz) + SW'(r_p_xw)) <<< 1;
        r_roll_x <= SW'(r_p_zz) + SW'(r_p_ww) - SW'(r_p_xx) - SW'(r_p_yy);
        r_yaw_y  <= (SW'(r_p_xy) + SW'(r_p_zw)) <<< 1;
        r_yaw_x  <= SW'(r_p_xx) + SW'(r_p_ww) - SW'(r_p_yy) - SW'(r_p_zz);
        r_s2_num <= (SW'(r_p_yw) - SW'(r_p_xz)) <<< 1;
    end

    // ------------------------------------------------------------------
    // Stage 3 and divider: s = |num| * 2^30 / den, one quotient bit a stage.
    // Entry 0 holds the magnitude and the saturation decision.
    // ------------------------------------------------------------------
    logic [DW-1:0]      r_dv_rem [0:DIV_STEPS];
    logic [DW-1:0]      r_dv_den [0:DIV_STEPS];
    logic [QB-1:0]      r_dv_q   [0:DIV_STEPS];
    logic [DIV_STEPS:0] r_dv_sat, r_dv_neg, r_dv_inv, r_dv_vld;
    logic [DW-1:0]      n_dv_rem [1:DIV_STEPS];
    logic [QB-1:0]      n_dv_q   [1:DIV_STEPS];
    logic signed [SW-1:0] w_abs;
    logic [DW-1:0]      w_mag;

    assign w_abs = r_s2_num[SW-1] ? -r_s2_num : r_s2_num;
    assign w_mag = w_abs[DW-1:0];

    always_comb begin
        logic [DW:0] t;
        t = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t = {r_dv_rem[k], 1'b0};
            if (t >= {1'b0, r_dv_den[k]}) begin
                n_dv_rem[k+1] = DW'(t - {1'b0, r_dv_den[k]});
                n_dv_q[k+1]   = {r_dv_q[k][QB-2:0], 1'b1};
            end else begin
                n_dv_rem[k+1] = t[DW-1:0];
                n_dv_q[k+1]   = {r_dv_q[k][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_rem[0] <= w_mag;
        r_dv_den[0] <= r_s2_den[DW-1:0];
        r_dv_q[0]   <= '0;
        r_dv_sat[0] <= (w_mag >= r_s2_den[DW-1:0]);
        r_dv_neg[0] <= r_s2_num[SW-1];
        r_dv_inv[0] <= r_s2_inv;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            r_dv_rem[k] <= n_dv_rem[k];
            r_dv_den[k] <= r_dv_den[k-1];
            r_dv_q[k]   <= n_dv_q[k];
            r_dv_sat[k] <= r_dv_sat[k-1];
            r_dv_neg[k] <= r_dv_neg[k-1];
            r_dv_inv[k] <= r_dv_inv[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Sign and saturate, square, then form 2^60 - s^2.
    // ------------------------------------------------------------------
    logic                  r_sg_vld, r_sg_inv, r_sq_vld, r_sq_inv;
    logic signed [SQW-1:0] r_sg_s, r_sq_s;
    logic [RMW-1:0]        r_sq_sq;
    logic signed [SQW-1:0] w_smag;
    logic signed [2*SQW-1:0] w_sq;

    assign w_smag = r_dv_sat[DIV_STEPS] ? SQW'(1 << QB) : SQW'(r_dv_q[DIV_STEPS]);
    assign w_sq   = r_sg_s * r_sg_s;

    always_ff @(posedge i_clk) begin
        r_sg_s   <= r_dv_neg[DIV_STEPS] ? -w_smag : w_smag;
        r_sg_inv <= r_dv_inv[DIV_STEPS];
        r_sq_s   <= r_sg_s;
        r_sq_sq  <= w_sq[RMW-1:0];
        r_sq_inv <= r_sg_inv;
    end

    // ------------------------------------------------------------------
    // Square root of the radicand, one root bit a stage, MSB first.
    // ------------------------------------------------------------------
    logic [RMW-1:0]        r_sr_rem [0:SQRT_STEPS];
    logic [SQRT_STEPS-1:0] r_sr_q   [0:SQRT_STEPS];
    logic signed [SQW-1:0] r_sr_s   [0:SQRT_STEPS];
    logic [SQRT_STEPS:0]   r_sr_inv, r_sr_vld;
    logic [RMW-1:0]        n_sr_rem [1:SQRT_STEPS];
    logic [SQRT_STEPS-1:0] n_sr_q   [1:SQRT_STEPS];

    always_comb begin
        logic [RMW:0] d;
        d = '0;
        for (int j = 0; j < SQRT_STEPS; j++) begin
            d = (RMW+1)'({r_sr_q[j], 2'b01}) << (2 * (SQRT_STEPS - 1 - j));
            if ({1'b0, r_sr_rem[j]} >= d) begin
                n_sr_rem[j+1] = RMW'({1'b0, r_sr_rem[j]} - d);
                n_sr_q[j+1]   = {r_sr_q[j][SQRT_STEPS-2:0], 1'b1};
            end else begin
                n_sr_rem[j+1] = r_sr_rem[j];
                n_sr_q[j+1]   = {r_sr_q[j][SQRT_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr_rem[0] <= RMW'({1'b1, {(2*QB){1'b0}}}) - r_sq_sq;
        r_sr_q[0]   <= '0;
        r_sr_s[0]   <= r_sq_s;
        r_sr_inv[0] <= r_sq_inv;
        for (int j = 1; j <= SQRT_STEPS; j++) begin
            r_sr_rem[j] <= n_sr_rem[j];
            r_sr_q[j]   <= n_sr_q[j];
            r_sr_s[j]   <= r_sr_s[j-1];
            r_sr_inv[j] <= r_sr_inv[j-1];
        end
    end

    // ------------------------------------------------------------------
    // Three CORDICs. Roll and yaw start early; their angles wait in a delay line until pitch is ready.
    // ------------------------------------------------------------------
    logic                 w_roll_vld, w_pit_vld, w_yaw_vld;
    logic signed [RW-1:0] w_roll_ang, w_pit_ang, w_yaw_ang;
    logic signed [CW-1:0] w_pit_x;

    assign w_pit_x = CW'({1'b0, r_sr_q[SQRT_STEPS]});

    qte_cordic u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s2_vld),
        .i_x     (CW'(r_roll_x)),
        .i_y     (CW'(r_roll_y)),
        .o_vld   (w_roll_vld),
        .o_ang   (w_roll_ang)
    );

    qte_cordic u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s2_vld),
        .i_x     (CW'(r_yaw_x)),
        .i_y     (CW'(r_yaw_y)),
        .o_vld   (w_yaw_vld),
        .o_ang   (w_yaw_ang)
    );

    qte_cordic u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_sr_vld[SQRT_STEPS]),
        .i_x     (w_pit_x),
        .i_y     (CW'(r_sr_s[SQRT_STEPS])),
        .o_vld   (w_pit_vld),
        .o_ang   (w_pit_ang)
    );

    logic signed [RW-1:0]  r_dl_roll [0:PDLY-1];
    logic signed [RW-1:0]  r_dl_yaw  [0:PDLY-1];
    logic [PDLY-1:0]       r_dl_vld;
    logic [CORDIC_LAT-1:0] r_iv_dl;

    always_ff @(posedge i_clk) begin
        r_dl_roll[0] <= w_roll_ang;
        r_dl_yaw[0]  <= w_yaw_ang;
        for (int k = 1; k < PDLY; k++) begin
            r_dl_roll[k] <= r_dl_roll[k-1];
            r_dl_yaw[k]  <= r_dl_yaw[k-1];
        end
        // advance the zero-norm flag alongside the pitch CORDIC
        r_iv_dl <= {r_iv_dl[CORDIC_LAT-2:0], r_sr_inv[SQRT_STEPS]};
    end

    // ------------------------------------------------------------------
    // Output register: clamp, negate yaw, force zero on an invalid word.
    // ------------------------------------------------------------------
    logic w_inv;
    logic signed [RW-1:0] w_roll_c, w_pit_c, w_yaw_c;

    assign w_inv    = r_iv_dl[CORDIC_LAT-1];
    assign w_roll_c = clamp_ang(r_dl_roll[PDLY-1], ROLL_LIM);
    assign w_yaw_c  = clamp_ang(r_dl_yaw[PDLY-1], ROLL_LIM);
    assign w_pit_c  = clamp_ang(w_pit_ang, PITCH_LIM);

    always_ff @(posedge i_clk) begin
        o_invalid   <= w_inv;
        o_roll_deg  <= w_inv ? '0 : w_roll_c[15:0];
        o_pitch_deg <= w_inv ? '0 : w_pit_c[14:0];
        o_yaw_deg   <= w_inv ? '0 : 16'(-w_yaw_c);
    end

    // valid bits for every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_dv_vld <= '0;
            r_sg_vld <= 1'b0;
            r_sq_vld <= 1'b0;
            r_sr_vld <= '0;
            r_dl_vld <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_dv_vld <= {r_dv_vld[DIV_STEPS-1:0], r_s2_vld};
            r_sg_vld <= r_dv_vld[DIV_STEPS];
            r_sq_vld <= r_sg_vld;
            r_sr_vld <= {r_sr_vld[SQRT_STEPS-1:0], r_sq_vld};
            r_dl_vld <= {r_dl_vld[PDLY-2:0], w_roll_vld};
            o_valid  <= w_pit_vld;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted word did not emerge after the pipeline latency");

    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pit_vld == r_dl_vld[PDLY-1]) && (w_roll_vld == w_yaw_vld))
        else $error("roll, pitch and yaw paths out of step");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |->
        (o_roll_deg == '0) && (o_pitch_deg == '0) && (o_yaw_deg == '0))
        else $error("invalid word carries non-zero angles");

endmodule
